// File: rtl/core/rffm_pkg.sv
// package: shared types and constants of the relay feedback fault monitor
package rffm_pkg;

    // filter limits of the confirmed state and of the fault counter
    localparam logic [7:0] STATE_FILTER = 8'd3;
    localparam logic [7:0] FAULT_FILTER = 8'd10;

    // configuration register indexes
    localparam logic CFG_EXTERNAL_RELAY_MODE    = 1'b0;
    localparam logic CFG_WAIT_FOR_CONTROL_TIMER = 1'b1;

    // one check transaction
    typedef struct packed {
        logic checks_inhibited;
        logic control_timer_active;
        logic feedback_seen_high;
        logic power_zero;
        logic commanded_open;
        logic clear_pending;
        logic mode_change;
        logic open_records_present;
        logic close_records_present;
        logic new_command;
    } t_in;

    // one result transaction
    typedef struct packed {
        logic reported_open;
        logic confirmed_open;
        logic relay_fault;
        logic fault_start_event;
        logic fault_end_event;
        logic store_status;
        logic report_open_success;
        logic report_close_success;
    } t_out;

    // configuration seen by the check logic
    typedef struct packed {
        logic external_relay_mode;
        logic wait_for_control_timer;
    } t_cfg;

endpackage

// File: rtl/core/rffm_in_stage.sv
// module: input register stage of the relay fault monitor
module rffm_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rffm_pkg::t_in i_data,
    output logic          o_valid,
    input  logic          i_advance,
    output rffm_pkg::t_in o_data
);

    logic          r_valid;
    rffm_pkg::t_in r_data;

    // stage takes a new transaction when empty or when its content moves on
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/rffm_check.sv
// module: relay check logic with filter counters and fault state
module rffm_check (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  rffm_pkg::t_cfg i_cfg,
    input  rffm_pkg::t_in  i_data,
    output rffm_pkg::t_out o_result
);

    logic [7:0] r_mismatch_count, n_mismatch_count;
    logic [7:0] r_match_count, n_match_count;
    logic [7:0] r_fault_count, n_fault_count;
    logic       r_fault_flag, n_fault_flag;
    logic       r_reported, n_reported;
    logic       r_confirmed, n_confirmed;
    logic       r_success, n_success;

    // next state and result of one check
    always_comb begin
        logic skip;
        logic mismatch;
        logic cmd_open;

        cmd_open         = i_data.commanded_open;
        n_mismatch_count = r_mismatch_count;
        n_match_count    = r_match_count;
        n_fault_count    = r_fault_count;
        n_fault_flag     = r_fault_flag;
        n_reported       = r_reported;
        n_confirmed      = r_confirmed;
        n_success        = i_data.new_command ? 1'b0 : r_success;
        o_result         = '0;
        skip             = 1'b0;

        // gating of the check
        if (i_data.checks_inhibited) begin
            n_fault_count = r_fault_flag ? rffm_pkg::FAULT_FILTER : 8'd0;
            skip          = 1'b1;
        end else if (i_data.control_timer_active &&
                     (!i_cfg.external_relay_mode || i_cfg.wait_for_control_timer)) begin
            skip = 1'b1;
        end

        mismatch = (cmd_open && (!i_data.power_zero || i_data.feedback_seen_high)) ||
                   (!cmd_open && i_data.power_zero && !i_data.feedback_seen_high &&
                    (!i_cfg.external_relay_mode || !i_data.clear_pending));

        if (!skip) begin
            if (mismatch) begin
                n_reported = !cmd_open;
                if (r_mismatch_count < rffm_pkg::STATE_FILTER) begin
                    n_mismatch_count = r_mismatch_count + 8'd1;
                end else begin
                    n_confirmed = !cmd_open;
                end
                n_match_count = 8'd0;
                // fault count is held while faulted
                if (!r_fault_flag) begin
                    if (r_fault_count < rffm_pkg::FAULT_FILTER) begin
                        n_fault_count = r_fault_count + 8'd1;
                    end else begin
                        o_result.fault_start_event = 1'b1;
                        n_fault_flag               = 1'b1;
                    end
                end
            end else begin
                n_reported = cmd_open;
                if (r_match_count < rffm_pkg::STATE_FILTER) begin
                    n_match_count = r_match_count + 8'd1;
                end else begin
                    n_confirmed = cmd_open;
                    // first confirmed match after a command
                    if (!n_success) begin
                        n_success             = 1'b1;
                        o_result.store_status = 1'b1;
                        o_result.report_open_success  = cmd_open &&
                            i_data.open_records_present && !i_data.mode_change;
                        o_result.report_close_success = !cmd_open &&
                            i_data.close_records_present && !i_data.mode_change;
                    end
                end
                n_mismatch_count = 8'd0;
                if (r_fault_count != 8'd0) begin
                    n_fault_count = r_fault_count - 8'd1;
                end else begin
                    o_result.fault_end_event = r_fault_flag;
                    n_fault_flag             = 1'b0;
                end
            end
        end

        o_result.reported_open  = n_reported;
        o_result.confirmed_open = n_confirmed;
        o_result.relay_fault    = n_fault_flag;
    end

    // state update once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mismatch_count <= 8'd0;
            r_match_count    <= 8'd0;
            r_fault_count    <= 8'd0;
            r_fault_flag     <= 1'b0;
            r_reported       <= 1'b0;
            r_confirmed      <= 1'b0;
            r_success        <= 1'b0;
        end else if (i_advance) begin
            r_mismatch_count <= n_mismatch_count;
            r_match_count    <= n_match_count;
            r_fault_count    <= n_fault_count;
            r_fault_flag     <= n_fault_flag;
            r_reported       <= n_reported;
            r_confirmed      <= n_confirmed;
            r_success        <= n_success;
        end
    end

endmodule

// File: rtl/core/rffm_out_stage.sv
// module: result register stage of the relay fault monitor
module rffm_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_src_valid,
    output logic           o_advance,
    input  rffm_pkg::t_out i_result,
    output logic           o_valid,
    input  logic           i_ready,
    output rffm_pkg::t_out o_data
);

    logic           r_valid;
    rffm_pkg::t_out r_data;

    // result moves in when the register is empty or being drained
    assign o_advance = i_src_valid && (!r_valid || i_ready);

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_data <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/relay_feedback_fault_monitor_core.sv
// top level: relay feedback fault monitor core
// Each input transaction is one periodic relay check; each produces exactly one
// result transaction. A transaction passes an input register, then the check
// logic updates the filter counters, fault state and success mark and loads
// the result register; one transaction per cycle is sustained while the
// output side takes results. When the result register holds a result not
// yet taken, the input register still takes one more transaction.
// Configuration writes (index 0 external relay mode, index 1 wait for
// control timer) act at once and are meant to be made while no check is in
// flight.
module relay_feedback_fault_monitor_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rffm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rffm_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic           i_cfg_data
);

    rffm_pkg::t_cfg r_cfg;
    rffm_pkg::t_in  stage_data;
    rffm_pkg::t_out check_result;
    logic           stage_valid;
    logic           advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rffm_pkg::CFG_EXTERNAL_RELAY_MODE:    r_cfg.external_relay_mode    <= i_cfg_data;
                rffm_pkg::CFG_WAIT_FOR_CONTROL_TIMER: r_cfg.wait_for_control_timer <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    rffm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .o_valid   (stage_valid),
        .i_advance (advance),
        .o_data    (stage_data)
    );

    // check logic and state
    rffm_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cfg     (r_cfg),
        .i_data    (stage_data),
        .o_result  (check_result)
    );

    // result register
    rffm_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_valid (stage_valid),
        .o_advance   (advance),
        .i_result    (check_result),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule

// File: verif/tb_relay_feedback_fault_monitor_core.sv
// testbench of the relay feedback fault monitor core: directed table and random checks
`timescale 1ns / 1ps

module tb_relay_feedback_fault_monitor_core;

    // one directed table row, repeated count times under one setting
    typedef struct {
        rffm_pkg::t_in  item;
        int unsigned    count;
        logic           ext;
        logic           wait_timer;
        logic           typed;
        rffm_pkg::t_out result;
    } t_check_row;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    rffm_pkg::t_in  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    rffm_pkg::t_out out_data;
    logic           cfg_we    = 1'b0;
    logic           cfg_index = rffm_pkg::CFG_EXTERNAL_RELAY_MODE;
    logic           cfg_data  = 1'b0;

    // predictor state and its copy of the registers
    logic [7:0] mismatch_run;
    logic [7:0] match_run;
    logic [7:0] fault_level;
    logic       faulted;
    logic       reported_state;
    logic       confirmed_state;
    logic       success_marked;
    logic       mode_external;
    logic       mode_wait_timer;

    rffm_pkg::t_out pending_results [$];
    int   error_count = 0;
    int   out_stall_left = 0;
    bit   no_idle = 1'b0;

    string result_field [0:7] = '{"report_close_success", "report_open_success",
        "store_status", "fault_end_event", "fault_start_event", "relay_fault",
        "confirmed_open", "reported_open"};

    // item bits, msb first: inhibited, timer, feedback, power zero, open, clear,
    //                       mode change, open records, close records, new command
    t_check_row directed_rows [0:10] = '{
        '{10'b1111111111,  1, 1'b0, 1'b0, 1'b1, 8'h00},
        '{10'b0000000000,  1, 1'b0, 1'b0, 1'b1, 8'h00},
        '{10'b0100000000,  1, 1'b0, 1'b0, 1'b1, 8'h00},
        '{10'b0000100000, 11, 1'b0, 1'b0, 1'b0, 8'h00},
        '{10'b1000100000,  1, 1'b0, 1'b0, 1'b0, 8'h00},
        '{10'b0001000000,  1, 1'b0, 1'b0, 1'b0, 8'h00},
        '{10'b0001100100,  4, 1'b0, 1'b0, 1'b0, 8'h00},
        '{10'b0000001011,  4, 1'b0, 1'b0, 1'b0, 8'h00},
        '{10'b0001010010,  1, 1'b1, 1'b0, 1'b0, 8'h00},
        '{10'b0101000000,  1, 1'b1, 1'b0, 1'b0, 8'h00},
        '{10'b0111111111,  1, 1'b1, 1'b1, 1'b0, 8'h00}
    };

    relay_feedback_fault_monitor_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("relay_feedback_fault_monitor_core: mismatch");
        $finish;
    end

    // one relay check: updates the filters, the fault and the success mark
    function automatic rffm_pkg::t_out check_relay(rffm_pkg::t_in c);
        rffm_pkg::t_out r;
        logic skip;
        logic mis;
        r = '0;
        skip = 1'b0;
        if (c.new_command) begin
            success_marked = 1'b0;
        end
        if (c.checks_inhibited) begin
            fault_level = faulted ? rffm_pkg::FAULT_FILTER : 8'd0;
            skip = 1'b1;
        end else if (c.control_timer_active && (!mode_external || mode_wait_timer)) begin
            skip = 1'b1;
        end
        if (!skip) begin
            mis = (c.commanded_open && (!c.power_zero || c.feedback_seen_high)) ||
                  (!c.commanded_open && c.power_zero && !c.feedback_seen_high &&
                   (!mode_external || !c.clear_pending));
            if (mis) begin
                reported_state = !c.commanded_open;
                if (mismatch_run < rffm_pkg::STATE_FILTER) begin
                    mismatch_run = mismatch_run + 8'd1;
                end else begin
                    confirmed_state = !c.commanded_open;
                end
                match_run = '0;
                // fault count held while faulted
                if (!faulted) begin
                    if (fault_level < rffm_pkg::FAULT_FILTER) begin
                        fault_level = fault_level + 8'd1;
                    end else begin
                        r.fault_start_event = 1'b1;
                        faulted = 1'b1;
                    end
                end
            end else begin
                reported_state = c.commanded_open;
                if (match_run < rffm_pkg::STATE_FILTER) begin
                    match_run = match_run + 8'd1;
                end else begin
                    confirmed_state = c.commanded_open;
                    // first confirmed match after a command
                    if (!success_marked) begin
                        success_marked = 1'b1;
                        r.store_status = 1'b1;
                        if (c.commanded_open) begin
                            r.report_open_success = c.open_records_present && !c.mode_change;
                        end else begin
                            r.report_close_success = c.close_records_present && !c.mode_change;
                        end
                    end
                end
                mismatch_run = '0;
                if (fault_level != 8'd0) begin
                    fault_level = fault_level - 8'd1;
                end else begin
                    r.fault_end_event = faulted;
                    faulted = 1'b0;
                end
            end
        end
        r.reported_open  = reported_state;
        r.confirmed_open = confirmed_state;
        r.relay_fault    = faulted;
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // random check whose evidence matches or contradicts the command
    function automatic rffm_pkg::t_in make_check(logic cmd_open, logic want_mismatch);
        rffm_pkg::t_in c;
        int            ev;
        c = rffm_pkg::t_in'($urandom_range(0, 1023));
        c.commanded_open       = cmd_open;
        c.checks_inhibited     = ($urandom_range(0, 29) == 0);
        c.control_timer_active = ($urandom_range(0, 9) == 0);
        c.new_command          = ($urandom_range(0, 19) == 0);
        c.mode_change          = ($urandom_range(0, 3) == 0);
        // power zero with feedback low agrees with open and contradicts closed
        if (cmd_open ^ want_mismatch) begin
            c.power_zero         = 1'b1;
            c.feedback_seen_high = 1'b0;
        end else begin
            ev = $urandom_range(0, 2);
            c.power_zero         = (ev == 2);
            c.feedback_seen_high = (ev != 0);
        end
        if (!cmd_open && want_mismatch && $urandom_range(0, 3) != 0) begin
            c.clear_pending = 1'b0;
        end
        return c;
    endfunction

    task automatic note_mismatch(string what);
        error_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    // drive one check transaction and queue its expected result
    task automatic send_check(rffm_pkg::t_in item, logic typed, rffm_pkg::t_out typed_result);
        int             gap;
        rffm_pkg::t_out predicted;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        predicted = check_relay(item);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // stop sending and wait until every result is back
    task automatic drain_checks();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both registers, written back to back
    task automatic write_config(logic ext, logic wait_timer);
        cfg_we    <= 1'b1;
        cfg_index <= rffm_pkg::CFG_EXTERNAL_RELAY_MODE;
        cfg_data  <= ext;
        @(posedge clk);
        cfg_index <= rffm_pkg::CFG_WAIT_FOR_CONTROL_TIMER;
        cfg_data  <= wait_timer;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_external   = ext;
        mode_wait_timer = wait_timer;
    endtask

    // result transactions and output stalls
    always @(posedge clk) begin
        rffm_pkg::t_out want;
        logic [7:0]     got_bits;
        logic [7:0]     want_bits;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result %h with no check pending", out_data));
            end else begin
                want      = pending_results.pop_front();
                got_bits  = out_data;
                want_bits = want;
                for (int b = 7; b >= 0; b--) begin
                    if (got_bits[b] !== want_bits[b]) begin
                        note_mismatch($sformatf("%s: got %b, expected %b",
                            result_field[b], got_bits[b], want_bits[b]));
                    end
                end
            end
        end
        if (out_stall_left > 0) begin
            out_stall_left <= out_stall_left - 1;
            out_ready      <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            out_stall_left <= pick_gap();
            out_ready      <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // stimulus
    initial begin
        logic          cur_ext;
        logic          cur_wait;
        logic          cmd;
        logic          want_mis;
        int            style;
        int            burst_len;
        int            sent;
        rffm_pkg::t_in item;
        logic phase_ext  [0:5] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        logic phase_wait [0:5] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        mismatch_run    = '0;
        match_run       = '0;
        fault_level     = '0;
        faulted         = 1'b0;
        reported_state  = 1'b0;
        confirmed_state = 1'b0;
        success_marked  = 1'b0;
        mode_external   = 1'b0;
        mode_wait_timer = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_config(1'b0, 1'b0);
        cur_ext  = 1'b0;
        cur_wait = 1'b0;

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].ext != cur_ext || directed_rows[i].wait_timer != cur_wait) begin
                drain_checks();
                cur_ext  = directed_rows[i].ext;
                cur_wait = directed_rows[i].wait_timer;
                write_config(cur_ext, cur_wait);
            end
            repeat (directed_rows[i].count) begin
                send_check(directed_rows[i].item, directed_rows[i].typed,
                           directed_rows[i].result);
            end
        end

        // random phases, one setting each
        for (int p = 0; p < 6; p++) begin
            drain_checks();
            write_config(phase_ext[p], phase_wait[p]);
            no_idle = (p == 3);
            sent = 0;
            while (sent < 158) begin
                burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                        : $urandom_range(1, 8);
                cmd   = 1'($urandom_range(0, 1));
                style = $urandom_range(0, 2);
                for (int k = 0; k < burst_len; k++) begin
                    want_mis = (style == 2) ? 1'($urandom_range(0, 1)) : (style == 0);
                    item = make_check(cmd, want_mis);
                    if (k == 0 && $urandom_range(0, 1) == 0) begin
                        item.new_command = 1'b1;
                    end
                    // noise transaction
                    if ($urandom_range(0, 11) == 0) begin
                        item = rffm_pkg::t_in'($urandom_range(0, 1023));
                    end
                    send_check(item, 1'b0, '0);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;

        drain_checks();
        if (pending_results.size() != 0) begin
            note_mismatch("expected results left over");
        end
        if (error_count == 0) begin
            $display("relay_feedback_fault_monitor_core: match");
        end else begin
            $display("relay_feedback_fault_monitor_core: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/rffm_pkg.sv
rtl/core/rffm_in_stage.sv
rtl/core/rffm_check.sv
rtl/core/rffm_out_stage.sv
rtl/core/relay_feedback_fault_monitor_core.sv
verif/tb_relay_feedback_fault_monitor_core.sv
